@@ src/assert_macros.svh @@
// Assertion macros shared by the blink frame fill RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/lbff_pkg.sv @@
// Package for the blink frame fill block: config struct, frame descriptor,
// result struct, register indexes and the divide-by-255 helper. No dependencies.
`default_nettype none

package lbff_pkg;

    localparam int LED_IDX_W  = 6;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFF   = 3'd5;

    typedef struct packed {
        logic [15:0] cycle_ms;
        logic [7:0]  brightness;
        logic [7:0]  range_start;
        logic [7:0]  range_end;
        logic [23:0] on_rgb;
        logic [23:0] off_rgb;
    } cfg_t;

    // One classified frame handed from front to back.
    typedef struct packed {
        logic              phase_on;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } frame_desc_t;

    typedef struct packed {
        logic                 last;
        logic                 phase_on;
        logic [CHAN_W-1:0]    blue;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    red;
        logic [LED_IDX_W-1:0] led_index;
    } led_res_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_MUL,
        FR_PUSH
    } front_state_t;

    // floor(x / 255), exact for any product of two bytes.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

@@ src/lbff_fifo.sv @@
// Small register queue between the frame front end and the LED emitter.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lbff_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !full || pop)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, not_empty)

endmodule

`default_nettype wire

@@ src/lbff_front.sv @@
// Front end: accepts frame requests, divides the time stamp by the period
// one quotient bit a cycle and scales the selected color. Depends on lbff_pkg.
`default_nettype none

module lbff_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lbff_pkg::cfg_t      cfg,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [5:0]          req_second,
    input  wire logic [9:0]          req_millisecond,
    output logic                     desc_push,
    output lbff_pkg::frame_desc_t    desc,
    input  wire logic                desc_full
);

    lbff_pkg::front_state_t state_reg, state_next;

    logic [15:0] dividend_reg;
    logic [15:0] period_reg;
    logic [15:0] rem_reg;
    logic [3:0]  step_reg;
    logic        qbit_reg;
    logic        phase_reg;
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;

    logic [16:0] shifted;
    logic        ge;
    logic [16:0] diff;
    logic [23:0] color;
    logic [15:0] total;

    assign total   = 16'({10'b0, req_second} * 16'd1000) + {6'b0, req_millisecond};
    assign shifted = {rem_reg, dividend_reg[15]};
    assign ge      = (shifted >= {1'b0, period_reg});
    assign diff    = shifted - {1'b0, period_reg};
    // Even quotient selects the on color.
    assign color   = qbit_reg ? cfg.off_rgb : cfg.on_rgb;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbff_pkg::FR_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lbff_pkg::FR_DIV;
                end
            end
            lbff_pkg::FR_DIV:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = lbff_pkg::FR_MUL;
                end
            end
            lbff_pkg::FR_MUL:
            begin
                state_next = lbff_pkg::FR_PUSH;
            end
            lbff_pkg::FR_PUSH:
            begin
                if (!desc_full)
                begin
                    state_next = lbff_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = lbff_pkg::FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        desc_push = 1'b0;
        case (state_reg)
            lbff_pkg::FR_IDLE: req_ready = 1'b1;
            lbff_pkg::FR_PUSH: desc_push = !desc_full;
            default:
            begin
                req_ready = 1'b0;
                desc_push = 1'b0;
            end
        endcase
    end

    assign desc.phase_on = phase_reg;
    assign desc.red      = lbff_pkg::div255(prod_r_reg);
    assign desc.green    = lbff_pkg::div255(prod_g_reg);
    assign desc.blue     = lbff_pkg::div255(prod_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbff_pkg::FR_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lbff_pkg::FR_DIV)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lbff_pkg::FR_IDLE:
            begin
                dividend_reg <= total;
                period_reg   <= (cfg.cycle_ms == 16'd0) ? 16'd1 : cfg.cycle_ms;
                rem_reg      <= '0;
            end
            lbff_pkg::FR_DIV:
            begin
                rem_reg      <= ge ? diff[15:0] : shifted[15:0];
                dividend_reg <= {dividend_reg[14:0], 1'b0};
                qbit_reg     <= ge;
            end
            lbff_pkg::FR_MUL:
            begin
                phase_reg  <= !qbit_reg;
                prod_r_reg <= color[23:16] * cfg.brightness;
                prod_g_reg <= color[15:8] * cfg.brightness;
                prod_b_reg <= color[7:0] * cfg.brightness;
            end
            default:
            begin
                phase_reg <= phase_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lbff_back.sv @@
// Back end: takes frame descriptors from the queue and emits one result per
// LED through an output register. Depends on lbff_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lbff_back #(
    parameter int NUM_LEDS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lbff_pkg::cfg_t        cfg,
    input  wire logic                  desc_valid,
    input  wire lbff_pkg::frame_desc_t desc,
    output logic                       desc_pop,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output lbff_pkg::led_res_t         res
);

    localparam int IW = lbff_pkg::LED_IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEDS - 1);

    logic                  active_reg;
    logic [IW-1:0]         idx_reg;
    lbff_pkg::frame_desc_t desc_reg;
    logic                  out_valid_reg;
    lbff_pkg::led_res_t    out_reg;

    logic adv;
    logic at_last;
    logic lit;

    assign adv      = active_reg && (!out_valid_reg || res_ready);
    assign at_last  = (idx_reg == LAST_IDX);
    assign desc_pop = desc_valid && (!active_reg || (adv && at_last));
    assign lit      = ({2'b0, idx_reg} >= cfg.range_start) && ({2'b0, idx_reg} <= cfg.range_end);

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (desc_pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (adv)
            begin
                active_reg <= !at_last;
                idx_reg    <= idx_reg + IW'(1);
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            desc_reg <= desc;
        end
        if (adv)
        begin
            out_reg.led_index <= idx_reg;
            out_reg.red       <= lit ? desc_reg.red : '0;
            out_reg.green     <= lit ? desc_reg.green : '0;
            out_reg.blue      <= lit ? desc_reg.blue : '0;
            out_reg.phase_on  <= desc_reg.phase_on;
            out_reg.last      <= at_last;
        end
    end

    `ASSERT_IMPLIES(a_last_index, clk, rst_n, res_valid && res.last, res.led_index == LAST_IDX)
    `ASSERT_NEXT(a_index_step, clk, rst_n, res_valid && res_ready && !res.last,
        res_valid && (res.led_index == $past(res.led_index) + IW'(1)))

endmodule

`default_nettype wire

@@ src/led_blink_frame_fill.sv @@
// Top level of the LED blink frame fill block: configuration registers,
// front end, descriptor queue and LED emitter. Depends on lbff_pkg and submodules.
//
// Usage:
//   s_* carries frame requests: tdata holds second then millisecond from bit 0.
//   Each request yields NUM_LEDS results on m_*, LED 0 first, tlast on the
//   final LED, tuser = phase_on (1 when the on color was chosen).
//   cfg_* writes one register per request: index 0 cycle_ms, 1 brightness,
//   2 range_start, 3 range_end, 4 on color, 5 off color; other indexes drop.
//   Write registers only while no frame is in flight.
// Processing:
//   The front end takes one request at a time: an accept, 16 restoring
//   divide steps of the time stamp by cycle_ms, a multiply and a push.
//   With the queue and emitter idle, a descriptor reaches m_tvalid through
//   the queue, active_reg and the output register. The emitter sends one
//   LED per cycle while m_tready is high; the queue hides the next divide.
// Reset and stall:
//   rst_n clears the queue, the emitter and the front end state, and sets the config registers to their defaults.
//   When m_tready is low the output register holds its result; the queue
//   and then s_tready back up behind it, and no result is dropped.
`default_nettype none

module led_blink_frame_fill #(
    parameter int NUM_LEDS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Frame requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // second[5:0], millisecond[15:6]
    // LED results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // led_index[5:0], red[13:6], green[21:14],
                                        // blue[29:22], zero[31:30]
    output logic             m_tuser,   // phase_on
    output logic             m_tlast,
    // Register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int DESC_W = $bits(lbff_pkg::frame_desc_t);

    lbff_pkg::cfg_t        cfg_reg;
    lbff_pkg::frame_desc_t front_desc;
    lbff_pkg::frame_desc_t queue_desc;
    lbff_pkg::led_res_t    res;

    logic desc_push;
    logic desc_full;
    logic desc_pop;
    logic desc_valid;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_ms    <= 16'd500;
            cfg_reg.brightness  <= 8'd255;
            cfg_reg.range_start <= 8'd0;
            cfg_reg.range_end   <= 8'd63;
            cfg_reg.on_rgb      <= 24'hFFFFFF;
            cfg_reg.off_rgb     <= 24'h000000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lbff_pkg::REG_CYCLE_MS:    cfg_reg.cycle_ms    <= cfg_data[15:0];
                lbff_pkg::REG_BRIGHTNESS:  cfg_reg.brightness  <= cfg_data[7:0];
                lbff_pkg::REG_RANGE_START: cfg_reg.range_start <= cfg_data[7:0];
                lbff_pkg::REG_RANGE_END:   cfg_reg.range_end   <= cfg_data[7:0];
                lbff_pkg::REG_COLOR_ON:    cfg_reg.on_rgb      <= cfg_data;
                lbff_pkg::REG_COLOR_OFF:   cfg_reg.off_rgb     <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Classify the request: blink phase and scaled color.
    lbff_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_second      (s_tdata[5:0]),
        .req_millisecond (s_tdata[15:6]),
        .desc_push       (desc_push),
        .desc            (front_desc),
        .desc_full       (desc_full)
    );

    // Hold finished descriptors while the emitter is busy.
    lbff_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (lbff_pkg::FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_data (front_desc),
        .full      (desc_full),
        .pop       (desc_pop),
        .pop_data  (queue_desc),
        .not_empty (desc_valid)
    );

    // Emit one LED per cycle while m_tready is high, black outside the lit range.
    lbff_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc_valid (desc_valid),
        .desc       (queue_desc),
        .desc_pop   (desc_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {2'b00, res.blue, res.green, res.red, res.led_index};
    assign m_tuser = res.phase_on;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ test/tb_led_blink_frame_fill.sv @@
`timescale 1ns / 100ps
// Testbench for led_blink_frame_fill: directed and random frame requests, a
// self-checking predictor per LED, and random stalls on both streams. Uses lbff_pkg.
module tb_led_blink_frame_fill;

    localparam int NUM_LEDS = 64;
    // 12 ns clock: the limit is many times the slowest legal run.
    localparam longint RUN_LIMIT_NS = 64'd24_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // second[5:0], millisecond[15:6]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // led_index[5:0], red[13:6], green[21:14], blue[29:22]
    logic        m_tuser;    // phase_on
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    // Shadow copy of the register file, updated on each accepted write.
    lbff_pkg::cfg_t     shadow_cfg;
    // LED colors still owed by the block, oldest first.
    lbff_pkg::led_res_t expected_leds[$];
    lbff_pkg::led_res_t got_led;
    int                 err_count;
    // Chance in percent of a stall burst on either stream; 0 disables idling.
    int                 idle_pct;

    led_blink_frame_fill #(
        .NUM_LEDS (NUM_LEDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("led_blink_frame_fill test failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Scale one channel by the brightness, floor(chan * bright / 255).
    function automatic logic [7:0] scale_chan(input logic [7:0] chan,
                                              input logic [7:0] bright);
        int unsigned prod;
        prod = int'(chan) * int'(bright);
        return 8'(prod / 255);
    endfunction

    // Work out the colors of one frame and queue one result per LED.
    task automatic predict_frame(input logic [5:0] sec, input logic [9:0] msec);
        int unsigned        stamp_ms;
        int unsigned        period;
        logic               on;
        logic [23:0]        color;
        logic [7:0]         r, g, b;
        logic               lit;
        lbff_pkg::led_res_t led;
        stamp_ms = int'(sec) * 1000 + int'(msec);
        // A zero half-period behaves like one millisecond.
        period   = (shadow_cfg.cycle_ms == 16'd0) ? 1 : int'(shadow_cfg.cycle_ms);
        on       = ((stamp_ms / period) % 2) == 0;
        color    = on ? shadow_cfg.on_rgb : shadow_cfg.off_rgb;
        r        = scale_chan(color[23:16], shadow_cfg.brightness);
        g        = scale_chan(color[15:8], shadow_cfg.brightness);
        b        = scale_chan(color[7:0], shadow_cfg.brightness);
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            // An inverted range or one past the strip lights nothing.
            lit           = (i >= int'(shadow_cfg.range_start)) &&
                            (i <= int'(shadow_cfg.range_end));
            led.led_index = 6'(i);
            led.red       = lit ? r : 8'd0;
            led.green     = lit ? g : 8'd0;
            led.blue      = lit ? b : 8'd0;
            led.phase_on  = on;
            led.last      = (i == NUM_LEDS - 1);
            expected_leds.push_back(led);
        end
    endtask

    // ---------------------------------------------------------------------
    // Result checker: compare every accepted LED with the oldest prediction
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_leds.size() == 0)
            begin
                $error("LED result with no frame request pending: tdata %h", m_tdata);
                err_count++;
            end
            else
            begin
                got_led = expected_leds.pop_front();
                check_field("led_index", got_led.led_index, m_tdata[5:0]);
                check_field("red",       got_led.red,       m_tdata[13:6]);
                check_field("green",     got_led.green,     m_tdata[21:14]);
                check_field("blue",      got_led.blue,      m_tdata[29:22]);
                check_field("phase_on",  got_led.phase_on,  m_tuser);
                check_field("last",      got_led.last,      m_tlast);
            end
        end
    end

    // Receiver back-pressure: random bursts of low tready at the falling edge.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers; every task starts and ends just after a falling edge
    // ---------------------------------------------------------------------

    // Send one frame request; hold tvalid high so requests can go back to back.
    task automatic send_frame(input logic [5:0] sec, input logic [9:0] msec);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {msec, sec};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_frame(sec, msec);
        @(negedge clk);
    endtask

    // Drop the request line and wait until every owed LED has come out.
    task automatic drain_frames();
        s_tvalid = 1'b0;
        while (expected_leds.size() != 0)
            @(negedge clk);
    endtask

    // Write one register; only call this with no frame in flight.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lbff_pkg::REG_CYCLE_MS:    shadow_cfg.cycle_ms    = value[15:0];
            lbff_pkg::REG_BRIGHTNESS:  shadow_cfg.brightness  = value[7:0];
            lbff_pkg::REG_RANGE_START: shadow_cfg.range_start = value[7:0];
            lbff_pkg::REG_RANGE_END:   shadow_cfg.range_end   = value[7:0];
            lbff_pkg::REG_COLOR_ON:    shadow_cfg.on_rgb      = value;
            lbff_pkg::REG_COLOR_OFF:   shadow_cfg.off_rgb     = value;
            default: ;  // unmapped index: the block drops the write
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset values: 500 ms half-period, full white on, black off, all lit.
    task automatic test_reset_defaults();
        send_frame(6'd0, 10'd0);        // quotient 0, on phase
        send_frame(6'd0, 10'd500);      // quotient 1, off phase
        send_frame(6'd59, 10'd999);     // top of the legal time range
        send_frame(6'd63, 10'd1023);    // out-of-range stamp, used as given
        drain_frames();
    endtask

    // A zero half-period counts as one, so the phase follows the lsb of the time.
    task automatic test_zero_period();
        write_reg(lbff_pkg::REG_CYCLE_MS, 24'h000000);
        write_reg(lbff_pkg::REG_COLOR_OFF, 24'h123456);
        send_frame(6'd0, 10'd0);
        send_frame(6'd0, 10'd1);
        send_frame(6'd42, 10'd777);
        drain_frames();
    endtask

    // Brightness at zero, one and half on uneven colors, then back to full.
    task automatic test_brightness_extremes();
        write_reg(lbff_pkg::REG_CYCLE_MS, 24'h0003E8);
        write_reg(lbff_pkg::REG_COLOR_ON, 24'hFF00FF);
        write_reg(lbff_pkg::REG_COLOR_OFF, 24'h80017F);
        write_reg(lbff_pkg::REG_BRIGHTNESS, 24'h000000);
        send_frame(6'd0, 10'd10);
        drain_frames();
        write_reg(lbff_pkg::REG_BRIGHTNESS, 24'h000001);
        send_frame(6'd1, 10'd10);
        drain_frames();
        write_reg(lbff_pkg::REG_BRIGHTNESS, 24'h000080);
        send_frame(6'd2, 10'd10);
        send_frame(6'd3, 10'd10);
        drain_frames();
        write_reg(lbff_pkg::REG_BRIGHTNESS, 24'h0000FF);
    endtask

    // Lit window: inverted, past the strip, single LED, last LED only, oversized.
    task automatic test_led_ranges();
        write_reg(lbff_pkg::REG_RANGE_START, 24'h000028);
        write_reg(lbff_pkg::REG_RANGE_END, 24'h000014);
        send_frame(6'd5, 10'd0);
        drain_frames();
        write_reg(lbff_pkg::REG_RANGE_START, 24'h000040);
        write_reg(lbff_pkg::REG_RANGE_END, 24'h0000FF);
        send_frame(6'd5, 10'd0);
        drain_frames();
        write_reg(lbff_pkg::REG_RANGE_START, 24'h000011);
        write_reg(lbff_pkg::REG_RANGE_END, 24'h000011);
        send_frame(6'd5, 10'd0);
        drain_frames();
        write_reg(lbff_pkg::REG_RANGE_START, 24'h00003F);
        write_reg(lbff_pkg::REG_RANGE_END, 24'h00003F);
        send_frame(6'd5, 10'd0);
        drain_frames();
        write_reg(lbff_pkg::REG_RANGE_START, 24'h000000);
        write_reg(lbff_pkg::REG_RANGE_END, 24'h0000FF);
        send_frame(6'd5, 10'd0);
        drain_frames();
    endtask

    // Largest and smallest half-period, then writes to unmapped indexes.
    task automatic test_period_and_unmapped();
        write_reg(lbff_pkg::REG_CYCLE_MS, 24'hFFFFFF);   // upper bits ignored, 65535 kept
        send_frame(6'd63, 10'd1023);
        drain_frames();
        write_reg(lbff_pkg::REG_CYCLE_MS, 24'h000001);
        send_frame(6'd7, 10'd333);
        drain_frames();
        write_reg(3'd6, 24'hABCDEF);
        write_reg(3'd7, 24'h000000);
        send_frame(6'd30, 10'd0);
        drain_frames();
    endtask

    // Pick a register value: often an extreme, otherwise random.
    function automatic logic [23:0] pick_value(input logic [23:0] max_val);
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return max_val;
            default: return 24'($urandom) & max_val;
        endcase
    endfunction

    // New random settings; upper data bits carry noise the block must drop.
    task automatic random_setup();
        logic [23:0] noise;
        logic [15:0] cyc;
        noise = 24'($urandom);
        // Keep most half-periods short so both phases show up.
        cyc   = ($urandom_range(0, 3) == 0) ? 16'(pick_value(24'hFFFF)) :
                16'($urandom_range(0, 1500));
        write_reg(lbff_pkg::REG_CYCLE_MS, {noise[23:16], cyc});
        write_reg(lbff_pkg::REG_BRIGHTNESS, {noise[15:0], 8'(pick_value(24'hFF))});
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(lbff_pkg::REG_RANGE_START, {noise[23:8], 8'(pick_value(24'hFF))});
            write_reg(lbff_pkg::REG_RANGE_END, {noise[15:0], 8'(pick_value(24'hFF))});
        end
        else
        begin
            write_reg(lbff_pkg::REG_RANGE_START, {noise[23:8], 8'($urandom_range(0, 70))});
            write_reg(lbff_pkg::REG_RANGE_END, {noise[15:0], 8'($urandom_range(0, 70))});
        end
        write_reg(lbff_pkg::REG_COLOR_ON, pick_value(24'hFFFFFF));
        write_reg(lbff_pkg::REG_COLOR_OFF, pick_value(24'hFFFFFF));
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(6, 7)), 24'($urandom));
    endtask

    // Phases of random frames, each under fresh settings and stall density.
    task automatic test_random_frames();
        logic [5:0] sec;
        logic [9:0] msec;
        for (int phase_n = 0; phase_n < 12; phase_n++)
        begin
            random_setup();
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 5;
                2: idle_pct = 20;
                default: idle_pct = 50;
            endcase
            for (int k = 0; k < 25; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    sec  = 6'($urandom);
                    msec = 10'($urandom);
                end
                else
                begin
                    sec  = 6'($urandom_range(0, 59));
                    msec = 10'($urandom_range(0, 999));
                end
                send_frame(sec, msec);
            end
            // Hold off the sender until the whole backlog has come out.
            drain_frames();
        end
    endtask

    // Closing stretch with neither side idling: requests back to back.
    task automatic test_steady_tail();
        idle_pct = 0;
        random_setup();
        for (int k = 0; k < 20; k++)
            send_frame(6'($urandom), 10'($urandom));
        drain_frames();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        err_count  = 0;
        idle_pct   = 0;
        shadow_cfg = '{cycle_ms: 16'd500, brightness: 8'd255, range_start: 8'd0,
                       range_end: 8'd63, on_rgb: 24'hFFFFFF, off_rgb: 24'h000000};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        idle_pct = 15;
        test_reset_defaults();
        test_zero_period();
        test_brightness_extremes();
        test_led_ranges();
        test_period_and_unmapped();
        test_random_frames();
        test_steady_tail();

        // Let any stray result surface before the verdict.
        repeat (40) @(negedge clk);
        if (expected_leds.size() != 0)
        begin
            $error("%0d LED results never arrived", expected_leds.size());
            err_count++;
        end
        if (err_count == 0)
            $display("led_blink_frame_fill test passed");
        else
            $display("led_blink_frame_fill test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lbff_pkg.sv
src/lbff_fifo.sv
src/lbff_front.sv
src/lbff_back.sv
src/led_blink_frame_fill.sv
test/tb_led_blink_frame_fill.sv
